/* hdl/periodic_timer_table_unit_defines.svh */
// Assertion macros for the periodic timer table RTL.
`ifndef PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent in a cycle implies consequent in the same cycle
`define PTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// condition holds at every clock edge out of reset
`define PTT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");
`else
`define PTT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PTT_ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif

`endif

/* hdl/ptt_pkg.sv */
// Types, constants and helpers of the periodic timer table.
package ptt_pkg;

    localparam int TIMER_COUNT = 8;
    localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int ID_W        = 3;
    localparam int IN_IDX_W    = 3;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int DATA_W      = 32;
    localparam int LATE_W      = 31;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam int S_TDATA_W   = 72;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 72;
    localparam int M_TUSER_W   = 2;

    localparam logic [1:0] FUNC_CREATE = 2'd0;
    localparam logic [1:0] FUNC_CHANGE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam logic [DATA_W-1:0] PERIOD_FREE   = '0;
    localparam logic [DATA_W-1:0] PERIOD_PAUSED = '1;

    typedef struct packed {
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] deadline;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        entry_t           wdata;
    } store_req_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } div_res_t;

    typedef struct packed {
        logic              status;
        logic [ID_W-1:0]   id;
        logic              fire;
        logic [LATE_W-1:0] late;
        logic [DATA_W-1:0] missed;
    } res_t;

    // legal period for create/change: non-negative or paused
    function automatic logic period_ok(input logic [DATA_W-1:0] p);
        return !p[DATA_W-1] || (p == PERIOD_PAUSED);
    endfunction

    // running timer: positive period
    function automatic logic period_active(input logic [DATA_W-1:0] p);
        return (p != PERIOD_FREE) && !p[DATA_W-1];
    endfunction

endpackage

/* hdl/ptt_store.sv */
// Timer entry memory with per-entry valid flags cleared at reset.
module ptt_store (
    input  logic               clk,
    input  logic               rst_n,
    input  ptt_pkg::store_req_t req,
    output ptt_pkg::entry_t    rd_data
);

    ptt_pkg::entry_t                  entry_mem [ptt_pkg::TIMER_COUNT];
    logic [ptt_pkg::TIMER_COUNT-1:0]  valid_reg;
    ptt_pkg::entry_t                  rd_data_reg;
    logic                             rd_valid_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            entry_mem[req.addr] <= req.wdata;
        end
        rd_data_reg <= entry_mem[req.addr];
    end

    // valid flags: an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* hdl/ptt_div.sv */
// Serial restoring divider, one quotient bit per cycle.
module ptt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ptt_pkg::div_req_t req,
    output ptt_pkg::div_res_t res
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [ptt_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [ptt_pkg::DATA_W-1:0]     rem_reg;
    logic [ptt_pkg::DATA_W-1:0]     quo_reg;
    logic [ptt_pkg::DATA_W-1:0]     dvs_reg;

    logic [ptt_pkg::DATA_W:0]       shifted;
    logic [ptt_pkg::DATA_W+1:0]     diff;
    logic                           ge;
    logic                           last_step;

    // trial subtract of the shifted partial remainder
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[ptt_pkg::DATA_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        ge        = !diff[ptt_pkg::DATA_W+1];
        last_step = (cnt_reg == ptt_pkg::DIV_CNT_W'(ptt_pkg::DATA_W - 1));
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[ptt_pkg::DATA_W-1:0] : shifted[ptt_pkg::DATA_W-1:0];
            quo_reg <= {quo_reg[ptt_pkg::DATA_W-2:0], ge};
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

/* hdl/periodic_timer_table_unit.sv */
// Create scans the slots in turn for the first free one; change rewrites one entry.
// Tick walks the entries in turn and runs the serial divider for each due entry
// (one quotient bit a cycle) to count the periods missed.
// Not ready while an item is in work; one result at a time through an output register.
// Reset (async, active low) clears the table at once through per-entry valid flags;
// no clearing pass is needed.
`include "periodic_timer_table_unit_defines.svh"

module periodic_timer_table_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now_ms[31:0], period_ms[63:32], timer_index[66:64], zero pad
    input  logic [ptt_pkg::S_TDATA_W-1:0]   s_tdata,
    // func[1:0]
    input  logic [ptt_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // timer_id[2:0], late_ms[33:3], missed_count[65:34], zero pad
    output logic [ptt_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[0], is_fire[1]
    output logic [ptt_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_C_RD   = 4'd2;
    localparam logic [3:0] ST_C_CHK  = 4'd3;
    localparam logic [3:0] ST_CH_RD  = 4'd4;
    localparam logic [3:0] ST_CH_CHK = 4'd5;
    localparam logic [3:0] ST_T_RD   = 4'd6;
    localparam logic [3:0] ST_T_CHK  = 4'd7;
    localparam logic [3:0] ST_T_DIV  = 4'd8;
    localparam logic [3:0] ST_T_FIRE = 4'd9;
    localparam logic [3:0] ST_END    = 4'd10;

    localparam int DW = ptt_pkg::DATA_W;

    logic [3:0]                    state_reg, state_next;
    logic [ptt_pkg::IDX_W-1:0]     ptr_reg, ptr_next;
    logic [ptt_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]                    func_reg, func_next;
    logic [DW-1:0]                 now_reg, now_next;
    logic [DW-1:0]                 per_reg, per_next;
    logic [ptt_pkg::IN_IDX_W-1:0]  idx_reg, idx_next;
    ptt_pkg::res_t                 held_reg, held_next;
    logic                          held_valid_reg, held_valid_next;
    ptt_pkg::res_t                 out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_last_reg, out_last_next;

    ptt_pkg::store_req_t           st_req;
    ptt_pkg::entry_t               rd;
    ptt_pkg::div_req_t             div_req;
    ptt_pkg::div_res_t             div_res;

    logic                          out_free;
    logic                          ptr_last;
    logic                          idx_bad;
    logic [ptt_pkg::IDX_W-1:0]     idx_addr;
    logic [ptt_pkg::LATE_W-1:0]    late;
    ptt_pkg::res_t                 err_res;

    ptt_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (st_req),
        .rd_data (rd)
    );

    ptt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    // helpers
    always_comb
    begin
        out_free = !out_valid_reg || m_tready;
        ptr_last = (ptr_reg == ptt_pkg::IDX_W'(ptt_pkg::TIMER_COUNT - 1));
        idx_bad  = ({{(DW - ptt_pkg::IN_IDX_W){1'b0}}, idx_reg} >= DW'(ptt_pkg::TIMER_COUNT));
        idx_addr = ptt_pkg::IDX_W'(idx_reg);
        late     = div_res.remainder[ptt_pkg::LATE_W-1:0] + 1'b1;
        err_res  = '{status: ptt_pkg::STATUS_ERR, id: '0, fire: 1'b0, late: '0, missed: '0};
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        func_next       = func_reg;
        now_next        = now_reg;
        per_next        = per_reg;
        idx_next        = idx_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        st_req.we       = 1'b0;
        st_req.addr     = (func_reg == ptt_pkg::FUNC_CHANGE) ? idx_addr : ptr_reg;
        st_req.wdata    = rd;
        div_req.start    = 1'b0;
        div_req.dividend = now_reg - rd.deadline - 1'b1;
        div_req.divisor  = rd.period;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next       = s_tuser[1:0];
                    now_next        = s_tdata[31:0];
                    per_next        = s_tdata[63:32];
                    idx_next        = s_tdata[66:64];
                    ptr_next        = '0;
                    cnt_next        = '0;
                    held_valid_next = 1'b0;
                    state_next      = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (func_reg)
                    ptt_pkg::FUNC_CREATE:
                    begin
                        if (!ptt_pkg::period_ok(per_reg) || per_reg == ptt_pkg::PERIOD_FREE)
                        begin
                            held_next       = err_res;
                            held_valid_next = 1'b1;
                            state_next      = ST_END;
                        end
                        else
                        begin
                            state_next = ST_C_RD;
                        end
                    end
                    ptt_pkg::FUNC_CHANGE:
                    begin
                        if (idx_bad || !ptt_pkg::period_ok(per_reg))
                        begin
                            held_next       = err_res;
                            held_valid_next = 1'b1;
                            state_next      = ST_END;
                        end
                        else
                        begin
                            state_next = ST_CH_RD;
                        end
                    end
                    ptt_pkg::FUNC_TICK:
                    begin
                        state_next = ST_T_RD;
                    end
                    default:
                    begin
                        held_next       = err_res;
                        held_valid_next = 1'b1;
                        state_next      = ST_END;
                    end
                endcase
            end
            ST_C_RD:
            begin
                state_next = ST_C_CHK;
            end
            // first free slot takes the timer
            ST_C_CHK:
            begin
                if (rd.period == ptt_pkg::PERIOD_FREE)
                begin
                    st_req.we             = 1'b1;
                    st_req.wdata.period   = per_reg;
                    st_req.wdata.deadline = (per_reg == ptt_pkg::PERIOD_PAUSED) ?
                                            rd.deadline : now_reg + per_reg;
                    held_next       = '{status: ptt_pkg::STATUS_OK,
                                        id: ptt_pkg::ID_W'(ptr_reg),
                                        fire: 1'b0, late: '0, missed: '0};
                    held_valid_next = 1'b1;
                    state_next      = ST_END;
                end
                else if (ptr_last)
                begin
                    held_next       = err_res;
                    held_valid_next = 1'b1;
                    state_next      = ST_END;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_C_RD;
                end
            end
            ST_CH_RD:
            begin
                state_next = ST_CH_CHK;
            end
            // new period; deadline follows for a running timer
            ST_CH_CHK:
            begin
                st_req.we           = 1'b1;
                st_req.wdata.period = per_reg;
                if (ptt_pkg::period_active(per_reg))
                begin
                    if (rd.period == ptt_pkg::PERIOD_PAUSED)
                    begin
                        st_req.wdata.deadline = now_reg + per_reg;
                    end
                    else
                    begin
                        st_req.wdata.deadline = rd.deadline + per_reg - rd.period;
                    end
                end
                held_next       = '{status: ptt_pkg::STATUS_OK, id: idx_reg,
                                    fire: 1'b0, late: '0, missed: '0};
                held_valid_next = 1'b1;
                state_next      = ST_END;
            end
            ST_T_RD:
            begin
                state_next = ST_T_CHK;
            end
            // due check; a due entry starts the divider
            ST_T_CHK:
            begin
                if (ptt_pkg::period_active(rd.period) && rd.deadline < now_reg)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_T_DIV;
                end
                else if (ptr_last)
                begin
                    state_next = ST_END;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_T_RD;
                end
            end
            ST_T_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = ST_T_FIRE;
                end
            end
            // advance deadline; previous fire goes out, this one is held
            ST_T_FIRE:
            begin
                if (!held_valid_reg || out_free)
                begin
                    st_req.we             = 1'b1;
                    st_req.wdata.deadline = now_reg - {1'b0, late} + rd.period;
                    if (held_valid_reg)
                    begin
                        out_next       = held_reg;
                        out_last_next  = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    held_next       = '{status: ptt_pkg::STATUS_OK,
                                        id: ptt_pkg::ID_W'(ptr_reg),
                                        fire: 1'b1, late: late,
                                        missed: div_res.quotient};
                    held_valid_next = 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                    if (cnt_next == ptt_pkg::CNT_W'(ptt_pkg::MAX_RESULTS) || ptr_last)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = ST_T_RD;
                    end
                end
            end
            // final result of the item carries last
            ST_END:
            begin
                if (!held_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = held_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ptr_reg        <= '0;
            cnt_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            cnt_reg        <= cnt_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        now_reg      <= now_next;
        per_reg      <= per_next;
        idx_reg      <= idx_next;
        held_reg     <= held_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_reg.fire, out_reg.status};
    assign m_tdata  = {{(ptt_pkg::M_TDATA_W - ptt_pkg::ID_W - ptt_pkg::LATE_W - DW){1'b0}},
                       out_reg.missed, out_reg.late, out_reg.id};

    // checks
    `PTT_ASSERT_IMPL(a_idle_nothing_held, clk, rst_n, s_tready, !held_valid_reg)
    `PTT_ASSERT_IMPL(a_div_done_in_wait, clk, rst_n, div_res.done, state_reg == ST_T_DIV)
    `PTT_ASSERT_ALWAYS(a_fire_count_bound, clk, rst_n, cnt_reg <= ptt_pkg::CNT_W'(ptt_pkg::MAX_RESULTS))

endmodule
